[hdl/alignment_variant_caller_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the alignment variant caller
// Same-cycle-implication and next-cycle-implication checks, clocked on clk
// and quiet while arst_n is low. Empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ALIGNMENT_VARIANT_CALLER_DEFINES_SVH
`define ALIGNMENT_VARIANT_CALLER_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent and consequent in the same cycle
`define AVC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("avc check failed");

// consequent in the cycle after the antecedent
`define AVC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("avc check failed");

`else

`define AVC_ASSERT_SAME(lbl, ante, cons)
`define AVC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hdl/avc_pkg.sv]
// ----------------------------------------------------------------------------
// avc_pkg
// Shared types and constants of the alignment variant caller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package avc_pkg;

	localparam int unsigned POS_BITS_DEF = 16;
	localparam int unsigned NUM_SLOTS    = 5;

	localparam logic [7:0] GAP_CHAR = 8'h2D;

	// event kinds
	localparam logic [2:0] EV_SUBST    = 3'd0;
	localparam logic [2:0] EV_DELETION = 3'd1;
	localparam logic [2:0] EV_INS_CHAR = 3'd2;
	localparam logic [2:0] EV_INS_END  = 3'd3;
	localparam logic [2:0] EV_RANGE    = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [16:0] pos;
		logic [15:0] span;
		logic [16:0] end_pos;
		logic [7:0]  ref_nuc;
		logic [7:0]  query_nuc;
	} event_t;

	function automatic logic is_base(input logic [7:0] c);
		return (c == 8'h41) || (c == 8'h43) || (c == 8'h47) || (c == 8'h54);
	endfunction

	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v != 16'hFFFF) ? v + 16'd1 : v;
	endfunction

endpackage

`default_nettype wire

[hdl/alignment_variant_caller.sv]
// ----------------------------------------------------------------------------
// alignment_variant_caller
// Walks a pairwise alignment column by column and streams variant events.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: one alignment column per word; tdata = ref_char, query_char,
//   tlast marks the final column. Master side: one event per word; tuser is
//   the event kind, tlast marks the last event caused by a column.
//   A column is held in an input register, then evaluated in one pass of
//   combinational logic that updates the running state and loads up to five
//   event slots (at most four are ever filled) into an output group register.
//   The events of a column are registered in the output group register
//   when the column is loaded from the input register.
//   Throughput: one column per cycle while each column gives at most one
//   event and m_tready is high; extra events hold the group until taken.
//   Columns with no event pass through without using the output.
//   Stall: while the master side stalls, the input register still takes one
//   more column, then s_tready drops until the group drains.
//   Reset: clears the running state (position 0, no open insertion or
//   deletion, alignment not started) and empties both registers.
//   The final column flushes an open insertion, reports the range and
//   returns the state to its reset value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "alignment_variant_caller_defines.svh"

module alignment_variant_caller #(
	parameter int unsigned POS_BITS = avc_pkg::POS_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// column input
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // ref_char[7:0], query_char[15:8]
	input  wire logic        s_tlast,   // last_column
	// event output
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // position[16:0], span[32:17],
	                                    // end_position[49:33], ref_nuc[57:50],
	                                    // query_nuc[65:58], zero[71:66]
	output logic [2:0]       m_tuser,   // event_kind
	output logic             m_tlast    // last_result
);

	localparam int unsigned NS = avc_pkg::NUM_SLOTS;

	// position truncated (or zero-extended) to the 17-bit event field
	function automatic logic [16:0] to_pos(input logic [POS_BITS-1:0] p);
		logic [POS_BITS+16:0] w;
		w = {17'd0, p};
		return w[16:0];
	endfunction

	// ---- input register ---------------------------------------------------
	logic       valid_s1;
	logic [7:0] ref_s1;
	logic [7:0] qry_s1;
	logic       last_s1;

	// ---- running state ----------------------------------------------------
	logic [POS_BITS-1:0] ref_pos_q;
	logic                ins_open_q;
	logic [POS_BITS-1:0] ins_start_q;
	logic [15:0]         ins_len_q;
	logic                before_q;
	logic [15:0]         del_cnt_q;
	logic [POS_BITS-1:0] del_start_q;
	logic [POS_BITS-1:0] aln_start_q;
	logic [POS_BITS-1:0] aln_end_q;

	// ---- output group -----------------------------------------------------
	avc_pkg::event_t ev_q [NS];
	logic [NS-1:0]   mask_q;

	// ---- next-state / event logic -----------------------------------------
	logic [POS_BITS-1:0] ref_pos_n, ins_start_n, del_start_n, aln_start_n, aln_end_n;
	logic                ins_open_n, before_n;
	logic [15:0]         ins_len_n, del_cnt_n;
	avc_pkg::event_t     ev_n [NS];
	logic [NS-1:0]       mask_n;
	logic                gap_r, gap_q;

	always_comb begin
		ref_pos_n   = ref_pos_q;
		ins_open_n  = ins_open_q;
		ins_start_n = ins_start_q;
		ins_len_n   = ins_len_q;
		before_n    = before_q;
		del_cnt_n   = del_cnt_q;
		del_start_n = del_start_q;
		aln_start_n = aln_start_q;
		aln_end_n   = aln_end_q;
		mask_n      = '0;
		for (int i = 0; i < NS; i++) begin
			ev_n[i] = '0;
		end
		gap_r = (ref_s1 == avc_pkg::GAP_CHAR);
		gap_q = (qry_s1 == avc_pkg::GAP_CHAR);

		// slot 0: insertion character, or close of an insertion
		if (gap_r) begin
			if (!ins_open_q) begin
				ins_open_n  = 1'b1;
				ins_start_n = ref_pos_q;
				ins_len_n   = avc_pkg::sat_inc16(16'd0);
			end else begin
				ins_len_n = avc_pkg::sat_inc16(ins_len_q);
			end
			mask_n[0]         = 1'b1;
			ev_n[0].kind      = avc_pkg::EV_INS_CHAR;
			ev_n[0].pos       = to_pos(ins_start_n);
			ev_n[0].span      = ins_len_n;
			ev_n[0].query_nuc = qry_s1;
		end else begin
			if (ins_open_q) begin
				mask_n[0]    = 1'b1;
				ev_n[0].kind = avc_pkg::EV_INS_END;
				ev_n[0].pos  = to_pos(ins_start_q);
				ev_n[0].span = ins_len_q;
			end
			ins_open_n = 1'b0;
			ins_len_n  = '0;

			if (!gap_q) begin
				if (before_q) begin
					aln_start_n = ref_pos_q;
					before_n    = 1'b0;
				end else if (del_cnt_q != '0) begin
					// slot 1: deletion closed by this query base
					mask_n[1]    = 1'b1;
					ev_n[1].kind = avc_pkg::EV_DELETION;
					ev_n[1].pos  = to_pos(del_start_q);
					ev_n[1].span = del_cnt_q;
					del_cnt_n    = '0;
				end
				aln_end_n = ref_pos_q;
			end

			if (!gap_q && (qry_s1 != ref_s1) && avc_pkg::is_base(qry_s1)) begin
				// slot 2: substitution
				mask_n[2]         = 1'b1;
				ev_n[2].kind      = avc_pkg::EV_SUBST;
				ev_n[2].pos       = to_pos(ref_pos_q);
				ev_n[2].ref_nuc   = ref_s1;
				ev_n[2].query_nuc = qry_s1;
			end else if (gap_q && !before_q) begin
				if (del_cnt_q == '0) begin
					del_start_n = ref_pos_q;
				end
				del_cnt_n = avc_pkg::sat_inc16(del_cnt_q);
			end

			if (ref_pos_q != '1) begin
				ref_pos_n = ref_pos_q + POS_BITS'(1);
			end
		end

		if (last_s1) begin
			// slot 3: flush of an insertion still open at the end
			if (ins_open_n) begin
				mask_n[3]    = 1'b1;
				ev_n[3].kind = avc_pkg::EV_INS_END;
				ev_n[3].pos  = to_pos(ins_start_n);
				ev_n[3].span = ins_len_n;
			end
			// slot 4: alignment range, -1 when no query base was seen outside an insertion
			mask_n[4]       = 1'b1;
			ev_n[4].kind    = avc_pkg::EV_RANGE;
			ev_n[4].pos     = before_n ? '1 : to_pos(aln_start_n);
			ev_n[4].end_pos = before_n ? '1 : to_pos(aln_end_n);
			// back to reset values
			ref_pos_n   = '0;
			ins_open_n  = 1'b0;
			ins_start_n = '0;
			ins_len_n   = '0;
			before_n    = 1'b1;
			del_cnt_n   = '0;
			del_start_n = '0;
			aln_start_n = '0;
			aln_end_n   = '0;
		end
	end

	// ---- handshake --------------------------------------------------------
	logic            single;
	logic            load;
	logic [NS-1:0]   mask_pop;
	avc_pkg::event_t head;

	assign single   = ($countones(mask_q) == 1);
	assign load     = valid_s1 && ((mask_q == '0) || (single && m_tready));
	assign s_tready = !valid_s1 || load;
	assign mask_pop = mask_q & (mask_q - NS'(1));

	// lowest filled slot is the head of the group
	always_comb begin
		head = '0;
		for (int i = NS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				head = ev_q[i];
			end
		end
	end

	assign m_tvalid = (mask_q != '0);
	assign m_tlast  = single;
	assign m_tuser  = head.kind;
	assign m_tdata  = {6'd0, head.query_nuc, head.ref_nuc, head.end_pos, head.span, head.pos};

	// ---- registers --------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ref_s1  <= s_tdata[7:0];
			qry_s1  <= s_tdata[15:8];
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_pos_q   <= '0;
			ins_open_q  <= 1'b0;
			ins_start_q <= '0;
			ins_len_q   <= '0;
			before_q    <= 1'b1;
			del_cnt_q   <= '0;
			del_start_q <= '0;
			aln_start_q <= '0;
			aln_end_q   <= '0;
			mask_q      <= '0;
		end else begin
			if (load) begin
				ref_pos_q   <= ref_pos_n;
				ins_open_q  <= ins_open_n;
				ins_start_q <= ins_start_n;
				ins_len_q   <= ins_len_n;
				before_q    <= before_n;
				del_cnt_q   <= del_cnt_n;
				del_start_q <= del_start_n;
				aln_start_q <= aln_start_n;
				aln_end_q   <= aln_end_n;
				mask_q      <= mask_n;
			end else if (m_tvalid && m_tready) begin
				mask_q <= mask_pop;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NS; i++) begin
				ev_q[i] <= ev_n[i];
			end
		end
	end

	// ---- checks -----------------------------------------------------------
	`AVC_ASSERT_NEXT(a_s1_held, valid_s1 && !load, valid_s1)
	`AVC_ASSERT_SAME(a_ins_len, ins_open_q, ins_len_q != '0)
	`AVC_ASSERT_SAME(a_del_after_start, del_cnt_q != '0, !before_q)
	`AVC_ASSERT_SAME(a_group_size, 1'b1, $countones(mask_q) <= 4)

endmodule

`default_nettype wire
